### hdl/pqir_pkg.sv
// shared types and codes for the sorted-list priority queue
`default_nettype none

package pqir_pkg;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } pqir_state_t;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam int unsigned ITEM_DATA_W = 32;
  localparam int unsigned PRIO_W      = 8;
  localparam int unsigned OCC_W       = 5;

  typedef struct packed {
    logic load;
    logic exec;
  } pqir_cmd_t;

endpackage

`default_nettype wire

### hdl/priority_queue_insert_remove.sv
// top level: bounded sorted priority queue with insert and remove transactions
// an accepted transaction is registered, then executed into the registered result
// a new transaction is taken only after the last one has executed (an accept state, then an
//   execute state in which every slot compares against the new priority and shifts in parallel)
// execution waits while a previous result is still pending at the output
// reset: synchronous, queue empty, no result pending; slot contents are undefined
`default_nettype none

module priority_queue_insert_remove
  import pqir_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned DATA_BITS   = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          mode,
  input  wire logic signed [ITEM_DATA_W-1:0] item_data,
  input  wire logic [PRIO_W-1:0]             item_priority,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [ITEM_DATA_W-1:0]      out_data,
  output logic [PRIO_W-1:0]                  out_priority,
  output logic [1:0]                         status,
  output logic [OCC_W-1:0]                   occupancy
);

  pqir_cmd_t cmd;

  pqir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  pqir_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DATA_BITS   (DATA_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .mode          (mode),
    .item_data     (item_data),
    .item_priority (item_priority),
    .out_data      (out_data),
    .out_priority  (out_priority),
    .status        (status),
    .occupancy     (occupancy)
  );

endmodule

`default_nettype wire

### hdl/pqir_ctrl.sv
// controller: accepts one transaction, runs it, holds the result handshake
`default_nettype none

module pqir_ctrl
  import pqir_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  output pqir_cmd_t      cmd
);

  pqir_state_t state;
  pqir_state_t state_next;
  logic        out_valid_next;
  logic        fire;

  assign fire = (state == ST_EXEC) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = fire;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // result register is free again once taken
  always_comb begin
    out_valid_next = out_valid;
    if (fire) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_EXEC))
    else $error("accepted transaction did not start execution");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (out_valid && state == ST_IDLE))
    else $error("execution did not produce a result");

  a_no_exec_over_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !(out_valid && out_stall))
    else $error("result overwritten while still pending");

endmodule

`default_nettype wire

### hdl/pqir_datapath.sv
// datapath: row of sorted slots with parallel compare and neighbor shifting
`default_nettype none

module pqir_datapath
  import pqir_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned DATA_BITS   = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire pqir_cmd_t                 cmd,
  input  wire logic                      mode,
  input  wire logic signed [ITEM_DATA_W-1:0] item_data,
  input  wire logic [PRIO_W-1:0]         item_priority,
  output logic signed [ITEM_DATA_W-1:0]  out_data,
  output logic [PRIO_W-1:0]              out_priority,
  output logic [1:0]                     status,
  output logic [OCC_W-1:0]               occupancy
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic                 item_mode;
  logic [DATA_BITS-1:0] item_word;
  logic [PRIO_W-1:0]    item_prio;

  logic [DATA_BITS-1:0] slot_data     [QUEUE_DEPTH];
  logic [PRIO_W-1:0]    slot_priority [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keep;

  logic [CW-1:0] entry_count;
  logic [CW-1:0] entry_count_next;
  logic          full;
  logic          empty;
  logic          insert_go;
  logic          remove_go;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode <= mode;
      item_word <= DATA_BITS'($unsigned(item_data));
      item_prio <= item_priority;
    end
  end

  assign full      = (entry_count == CW'(QUEUE_DEPTH));
  assign empty     = (entry_count == '0);
  assign insert_go = cmd.exec && (item_mode == MODE_INSERT) && !full;
  assign remove_go = cmd.exec && (item_mode == MODE_REMOVE) && !empty;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
    // held entries at or above the new priority stay put; prefix since sorted
    assign keep[g] = (CW'(g) < entry_count) && (slot_priority[g] >= item_prio);

    logic take_new;
    if (g == 0) begin : g_head
      assign take_new = 1'b1;
    end else begin : g_body
      assign take_new = keep[g-1];
    end

    always_ff @(posedge clk) begin
      if (insert_go && !keep[g]) begin
        if (take_new) begin
          slot_data[g]     <= item_word;
          slot_priority[g] <= item_prio;
        end else begin
          slot_data[g]     <= slot_data[(g == 0) ? 0 : g - 1];
          slot_priority[g] <= slot_priority[(g == 0) ? 0 : g - 1];
        end
      end else if (remove_go && (g < QUEUE_DEPTH - 1)) begin
        slot_data[g]     <= slot_data[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
        slot_priority[g] <= slot_priority[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
      end
    end
  end

  always_comb begin
    entry_count_next = entry_count;
    if (insert_go) begin
      entry_count_next = entry_count + CW'(1);
    end else if (remove_go) begin
      entry_count_next = entry_count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else begin
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data     <= '0;
      out_priority <= '0;
      status       <= STATUS_DONE;
      occupancy    <= OCC_W'(entry_count_next);
      if (item_mode == MODE_INSERT) begin
        if (full) begin
          status <= STATUS_FULL;
        end
      end else begin
        if (empty) begin
          status <= STATUS_EMPTY;
        end else begin
          out_data     <= ITEM_DATA_W'(slot_data[0]);
          out_priority <= slot_priority[0];
        end
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    insert_go |=> (entry_count == $past(entry_count) + CW'(1)))
    else $error("insert did not add one entry");

  a_remove_front: assert property (@(posedge clk) disable iff (rst)
    remove_go |=> (out_priority == $past(slot_priority[0])))
    else $error("remove did not return the front entry");

endmodule

`default_nettype wire
